// ===== hdl/sdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment descriptor pool package
// Shared widths, codes and types for the segment descriptor pool.
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int unsigned POOL_ENTRIES_DEF = 32;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned BASE_W   = 24;
    localparam int unsigned SIZE_W   = 17;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned ENTRY_W  = 5;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UNMAP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef enum logic [1:0] {
        OP_MAP,
        OP_UNMAP,
        OP_QUERY,
        OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EXEC,
        BS_READ
    } t_bstate;

    typedef struct packed {
        t_op                op;
        logic [BASE_W-1:0]  base;
        logic [LIMIT_W-1:0] limit;
        logic [ENTRY_W-1:0] entry;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qreq;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [LIMIT_W-1:0] limit;
    } t_desc;

endpackage
`default_nettype wire

// ===== hdl/segment_descriptor_pool_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment descriptor pool
// Lowest-free-entry allocator over a pool of segment descriptors.
// Throughput: one map or unmap per cycle while the output is not stalled; a
// query takes an extra read state, set by the registered read port of the
// descriptor memory.
// Reset clears the in-use bitmap, the hint, the queue and the output valid
// flag; the descriptor memory and the output data registers are not cleared.
// ----------------------------------------------------------------------------
module segment_descriptor_pool_top #(
    parameter int unsigned POOL_ENTRIES = sdp_pkg::POOL_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [sdp_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [sdp_pkg::BASE_W-1:0]    i_phys_base,
    input  wire logic [sdp_pkg::SIZE_W-1:0]    i_byte_size,
    input  wire logic [sdp_pkg::ENTRY_W-1:0]   i_entry_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [sdp_pkg::STATUS_W-1:0]       o_status,
    output logic [sdp_pkg::ENTRY_W-1:0]        o_entry_out,
    output logic [sdp_pkg::BASE_W-1:0]         o_base_out,
    output logic [sdp_pkg::LIMIT_W-1:0]        o_limit_out
);
    import sdp_pkg::*;

    t_qreq w_qreq;
    logic  w_q_pop;

    sdp_front #(
        .POOL_ENTRIES(POOL_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_phys_base (i_phys_base),
        .i_byte_size (i_byte_size),
        .i_entry_in  (i_entry_in),
        .o_qreq      (w_qreq),
        .i_q_pop     (w_q_pop)
    );

    sdp_back #(
        .POOL_ENTRIES(POOL_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qreq      (w_qreq),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_entry_out (o_entry_out),
        .o_base_out  (o_base_out),
        .o_limit_out (o_limit_out)
    );

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_INVALID)) |-> (o_base_out == '0 && o_limit_out == '0))
        else $error("invalid result carries descriptor data");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY))
            |-> (o_entry_out == '0 && o_base_out == '0 && o_limit_out == '0))
        else $error("pool-empty result carries nonzero fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_INVALID))
        else $error("result status is not a defined code");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("output valid or input stall set right after reset");
`endif

endmodule
`default_nettype wire

// ===== hdl/sdp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment descriptor pool front end
// Accepts request words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module sdp_front #(
    parameter int unsigned POOL_ENTRIES = sdp_pkg::POOL_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [sdp_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [sdp_pkg::BASE_W-1:0]    i_phys_base,
    input  wire logic [sdp_pkg::SIZE_W-1:0]    i_byte_size,
    input  wire logic [sdp_pkg::ENTRY_W-1:0]   i_entry_in,
    output sdp_pkg::t_qreq                     o_qreq,
    input  wire logic                          i_q_pop
);
    import sdp_pkg::*;

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_out_of_range;

    assign o_in_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;

    assign w_out_of_range = (32'(i_entry_in) >= 32'(POOL_ENTRIES));

    always_comb begin
        w_cmd.base  = i_phys_base;
        w_cmd.limit = LIMIT_W'(i_byte_size - SIZE_W'(1));
        w_cmd.entry = i_entry_in;
        if (i_action == ACT_MAP) begin
            w_cmd.op = OP_MAP;
        end else if (w_out_of_range) begin
            w_cmd.op = OP_BAD;
        end else if (i_action == ACT_UNMAP) begin
            w_cmd.op = OP_UNMAP;
        end else if (i_action == ACT_QUERY) begin
            w_cmd.op = OP_QUERY;
        end else begin
            w_cmd.op = OP_BAD;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (w_push && !i_q_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_qreq.valid = (r_count != '0);
    assign o_qreq.cmd   = r_queue[r_rd_ptr];

endmodule
`default_nettype wire

// ===== hdl/sdp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment descriptor pool back end
// Executes map, unmap and query words against the bitmap and descriptor memory.
// ----------------------------------------------------------------------------
module sdp_back #(
    parameter int unsigned POOL_ENTRIES = sdp_pkg::POOL_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sdp_pkg::t_qreq                i_qreq,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [sdp_pkg::STATUS_W-1:0]       o_status,
    output logic [sdp_pkg::ENTRY_W-1:0]        o_entry_out,
    output logic [sdp_pkg::BASE_W-1:0]         o_base_out,
    output logic [sdp_pkg::LIMIT_W-1:0]        o_limit_out
);
    import sdp_pkg::*;

    localparam int unsigned IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int unsigned HINT_W = $clog2(POOL_ENTRIES + 1);

    t_bstate                r_state;
    t_bstate                n_state;
    t_cmd                   r_cmd;
    logic [POOL_ENTRIES-1:0] r_in_use;
    logic [POOL_ENTRIES-1:0] n_in_use;
    logic [HINT_W-1:0]      r_hint;
    logic [HINT_W-1:0]      n_hint;
    t_desc                  r_mem [POOL_ENTRIES];
    t_desc                  r_rd_data;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [ENTRY_W-1:0]     r_out_entry;
    logic [BASE_W-1:0]      r_out_base;
    logic [LIMIT_W-1:0]     r_out_limit;

    logic [POOL_ENTRIES-1:0] w_free;
    logic                   w_found;
    logic [IDX_W-1:0]       w_found_idx;
    logic [IDX_W-1:0]       w_cmd_idx;
    logic                   w_out_free;
    logic                   w_done;
    logic                   w_res_load;
    logic                   w_mem_we;
    logic                   w_mem_re;
    logic [STATUS_W-1:0]    w_res_status;
    logic [ENTRY_W-1:0]     w_res_entry;
    logic [BASE_W-1:0]      w_res_base;
    logic [LIMIT_W-1:0]     w_res_limit;

    assign w_cmd_idx  = IDX_W'(r_cmd.entry);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            w_free[i] = !r_in_use[i] && (HINT_W'(i) >= r_hint);
        end
    end

    always_comb begin
        w_found     = 1'b0;
        w_found_idx = '0;
        for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_found     = 1'b1;
                w_found_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_in_use     = r_in_use;
        n_hint       = r_hint;
        o_q_pop      = 1'b0;
        w_done       = 1'b0;
        w_res_load   = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        w_res_status = ST_OK;
        w_res_entry  = r_cmd.entry;
        w_res_base   = '0;
        w_res_limit  = '0;
        case (r_state)
            BS_IDLE: begin
                if (i_qreq.valid) begin
                    o_q_pop = 1'b1;
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                if (r_cmd.op == OP_QUERY) begin
                    w_mem_re = 1'b1;
                    n_state  = BS_READ;
                end else if (w_out_free) begin
                    w_res_load = 1'b1;
                    w_done     = 1'b1;
                    case (r_cmd.op)
                        OP_MAP: begin
                            if (w_found) begin
                                w_mem_we              = 1'b1;
                                n_in_use[w_found_idx] = 1'b1;
                                n_hint      = HINT_W'(w_found_idx) + HINT_W'(1);
                                w_res_entry = ENTRY_W'(w_found_idx);
                                w_res_base  = r_cmd.base;
                                w_res_limit = r_cmd.limit;
                            end else begin
                                w_res_status = ST_EMPTY;
                                w_res_entry  = '0;
                            end
                        end
                        OP_UNMAP: begin
                            n_in_use[w_cmd_idx] = 1'b0;
                            if (r_hint > HINT_W'(w_cmd_idx)) begin
                                n_hint = HINT_W'(w_cmd_idx);
                            end
                        end
                        default: begin
                            w_res_status = ST_INVALID;
                        end
                    endcase
                end
            end
            BS_READ: begin
                if (w_out_free) begin
                    w_res_load  = 1'b1;
                    w_done      = 1'b1;
                    w_res_base  = r_rd_data.base;
                    w_res_limit = r_rd_data.limit;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
        if (w_done) begin
            if (i_qreq.valid) begin
                o_q_pop = 1'b1;
                n_state = BS_EXEC;
            end else begin
                n_state = BS_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_in_use    <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_hint   <= n_hint;
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_qreq.cmd;
        end
        if (w_res_load) begin
            r_out_status <= w_res_status;
            r_out_entry  <= w_res_entry;
            r_out_base   <= w_res_base;
            r_out_limit  <= w_res_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_found_idx] <= '{base: r_cmd.base, limit: r_cmd.limit};
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_cmd_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_entry_out = r_out_entry;
    assign o_base_out  = r_out_base;
    assign o_limit_out = r_out_limit;

endmodule
`default_nettype wire

// ===== dv/sdp_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment descriptor pool reply checker
// Watches the request and reply channels of the pool. It keeps its own copy
// of the in-use bitmap, the descriptors and the first-free hint, and works
// out the reply to each accepted request word. Each accepted reply word is
// compared field by field with the oldest reply still due.
// ----------------------------------------------------------------------------
module sdp_reply_checker #(
    parameter int unsigned POOL_ENTRIES = sdp_pkg::POOL_ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  wire logic [sdp_pkg::ACTION_W-1:0]     i_action,
    input  wire logic [sdp_pkg::BASE_W-1:0]       i_phys_base,
    input  wire logic [sdp_pkg::SIZE_W-1:0]       i_byte_size,
    input  wire logic [sdp_pkg::ENTRY_W-1:0]      i_entry_in,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic [sdp_pkg::STATUS_W-1:0]     i_status,
    input  wire logic [sdp_pkg::ENTRY_W-1:0]      i_entry_out,
    input  wire logic [sdp_pkg::BASE_W-1:0]       i_base_out,
    input  wire logic [sdp_pkg::LIMIT_W-1:0]      i_limit_out,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output logic [POOL_ENTRIES-1:0]               o_written
);
    import sdp_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry;
        logic [BASE_W-1:0]   base;
        logic [LIMIT_W-1:0]  limit;
    } t_reply;

    logic [POOL_ENTRIES-1:0] busy = '0;
    logic [POOL_ENTRIES-1:0] written = '0;
    logic [BASE_W-1:0]       base_mem [POOL_ENTRIES];
    logic [LIMIT_W-1:0]      limit_mem [POOL_ENTRIES];
    int unsigned             hint = 0;
    t_reply                  replies_due [$];
    t_reply                  due;
    int                      fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_written    = '0;
    end

    function automatic t_reply pool_reply(input logic [ACTION_W-1:0] act,
                                          input logic [BASE_W-1:0]   base,
                                          input logic [SIZE_W-1:0]   size,
                                          input logic [ENTRY_W-1:0]  entry);
        t_reply r;
        bit     found;
        r     = '0;
        found = 1'b0;
        if (act == ACT_MAP) begin
            r.status = ST_EMPTY;
            for (int unsigned i = 0; i < POOL_ENTRIES; i++) begin
                if (!found && i >= hint && !busy[i]) begin
                    found        = 1'b1;
                    busy[i]      = 1'b1;
                    written[i]   = 1'b1;
                    base_mem[i]  = base;
                    limit_mem[i] = size[LIMIT_W-1:0] - 1'b1;
                    hint         = i + 1;
                    r.status     = ST_OK;
                    r.entry      = ENTRY_W'(i);
                    r.base       = base_mem[i];
                    r.limit      = limit_mem[i];
                end
            end
        end else if ((act != ACT_UNMAP && act != ACT_QUERY) || entry >= POOL_ENTRIES) begin
            r.status = ST_INVALID;
            r.entry  = entry;
        end else if (act == ACT_UNMAP) begin
            busy[entry] = 1'b0;
            if (hint > entry) begin
                hint = entry;
            end
            r.status = ST_OK;
            r.entry  = entry;
        end else begin
            r.status = ST_OK;
            r.entry  = entry;
            r.base   = base_mem[entry];
            r.limit  = limit_mem[entry];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            busy    = '0;
            written = '0;
            hint    = 0;
            replies_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                replies_due.push_back(pool_reply(i_action, i_phys_base, i_byte_size,
                                                 i_entry_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply word with none expected, got status %0d entry %0d",
                             $time, i_status, i_entry_out);
                    fails++;
                end else begin
                    due = replies_due.pop_front();
                    check_field("status", 32'(due.status), 32'(i_status));
                    check_field("entry", 32'(due.entry), 32'(i_entry_out));
                    check_field("base", 32'(due.base), 32'(i_base_out));
                    check_field("limit", 32'(due.limit), 32'(i_limit_out));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= replies_due.size();
        o_written    <= written;
    end

endmodule

// ===== dv/tb_segment_descriptor_pool_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment descriptor pool testbench
// Drives a short directed run over the size extremes, every action, unmap
// and query of free entries and the unused action code, then about 1300
// random request words in fill, drain and mixed phases. The sender works in
// bursts and the receiver stalls on a changing pattern; the checker module
// predicts and compares every reply word.
// ----------------------------------------------------------------------------
module tb_segment_descriptor_pool_top;
    import sdp_pkg::*;

    localparam int unsigned         ENTRIES   = POOL_ENTRIES_DEF;
    localparam logic [ACTION_W-1:0] ACT_RSVD  = ACTION_W'(OP_BAD);
    localparam logic [SIZE_W-1:0]   SIZE_64K  = SIZE_W'(65536);
    localparam logic [SIZE_W-1:0]   SIZE_MAX  = {SIZE_W{1'b1}};
    localparam logic [BASE_W-1:0]   BASE_MAX  = {BASE_W{1'b1}};
    localparam int                  RANDOM_WORDS = 1300;

    typedef enum logic [1:0] { MIX_FILL, MIX_DRAIN, MIX_BALANCED } t_mix;
    typedef enum logic [1:0] { RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC } t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [ACTION_W-1:0]   i_action    = '0;
    logic [BASE_W-1:0]     i_phys_base = '0;
    logic [SIZE_W-1:0]     i_byte_size = '0;
    logic [ENTRY_W-1:0]    i_entry_in  = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [ENTRY_W-1:0]    o_entry_out;
    logic [BASE_W-1:0]     o_base_out;
    logic [LIMIT_W-1:0]    o_limit_out;

    int                    fail_count;
    int                    pending;
    logic [ENTRIES-1:0]    written;

    int unsigned           burst_left = 0;
    t_rx_mode              rx_mode    = RX_FREE;
    int unsigned           rx_span    = 0;
    int unsigned           rx_phase   = 0;

    segment_descriptor_pool_top #(
        .POOL_ENTRIES (ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_phys_base (i_phys_base),
        .i_byte_size (i_byte_size),
        .i_entry_in  (i_entry_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_entry_out (o_entry_out),
        .o_base_out  (o_base_out),
        .o_limit_out (o_limit_out)
    );

    sdp_reply_checker #(
        .POOL_ENTRIES (ENTRIES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_phys_base  (i_phys_base),
        .i_byte_size  (i_byte_size),
        .i_entry_in   (i_entry_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_entry_out  (o_entry_out),
        .i_base_out   (o_base_out),
        .i_limit_out  (o_limit_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_written    (written)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(3));
            rx_span = $urandom_range(10, 120);
        end else begin
            rx_span--;
        end
        rx_phase++;
        case (rx_mode)
            RX_FREE:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(3) == 0);
            RX_HEAVY: i_out_stall <= ($urandom_range(9) < 7);
            default:  i_out_stall <= (rx_phase % 3 != 0);
        endcase
    end

    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic [BASE_W-1:0]   base,
                             input logic [SIZE_W-1:0]   size,
                             input logic [ENTRY_W-1:0]  entry);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_phys_base <= base;
        i_byte_size <= size;
        i_entry_in  <= entry;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic random_word(input t_mix mix);
        int unsigned         roll;
        int unsigned         e;
        logic [ACTION_W-1:0] act;
        logic [BASE_W-1:0]   base;
        logic [SIZE_W-1:0]   size;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  act = roll < 78 ? ACT_MAP : roll < 88 ? ACT_UNMAP :
                             roll < 97 ? ACT_QUERY : ACT_RSVD;
            MIX_DRAIN: act = roll < 15 ? ACT_MAP : roll < 80 ? ACT_UNMAP :
                             roll < 97 ? ACT_QUERY : ACT_RSVD;
            default:   act = roll < 40 ? ACT_MAP : roll < 70 ? ACT_UNMAP :
                             roll < 95 ? ACT_QUERY : ACT_RSVD;
        endcase
        e = $urandom_range(ENTRIES - 1);
        // A query only goes to an entry that has held a descriptor.
        if (act == ACT_QUERY) begin
            if (written == '0) begin
                act = ACT_MAP;
            end else begin
                while (!written[e]) e = (e + 1) % ENTRIES;
            end
        end
        roll = $urandom_range(15);
        base = roll == 0 ? BASE_W'(0) : roll == 1 ? BASE_MAX : BASE_W'($urandom);
        roll = $urandom_range(15);
        size = roll == 0 ? SIZE_W'(0) : roll == 1 ? SIZE_64K :
               roll == 2 ? SIZE_W'($urandom) : SIZE_W'($urandom_range(1, 65536));
        send_word(act, base, size, ENTRY_W'(e));
    endtask

    initial begin
        t_mix        mix;
        int unsigned span;
        mix  = MIX_FILL;
        span = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(ACT_MAP, BASE_W'(0), SIZE_W'(1), ENTRY_W'(0));
        send_word(ACT_MAP, BASE_MAX, SIZE_64K, ENTRY_W'(31));
        send_word(ACT_MAP, BASE_W'(24'h5A5A5A), SIZE_W'(0), ENTRY_W'(0));
        send_word(ACT_MAP, BASE_W'(24'hA5A5A5), SIZE_MAX, ENTRY_W'(31));
        send_word(ACT_MAP, BASE_W'(24'h123456), SIZE_W'(65537), ENTRY_W'(7));
        for (int q = 0; q < 5; q++) begin
            send_word(ACT_QUERY, BASE_W'(0), SIZE_W'(0), ENTRY_W'(q));
        end
        send_word(ACT_UNMAP, BASE_W'(0), SIZE_W'(0), ENTRY_W'(1));
        send_word(ACT_UNMAP, BASE_W'(0), SIZE_W'(0), ENTRY_W'(1));
        send_word(ACT_QUERY, BASE_W'(0), SIZE_W'(0), ENTRY_W'(1));
        send_word(ACT_MAP, BASE_W'(24'h00FF00), SIZE_W'(256), ENTRY_W'(0));
        send_word(ACT_UNMAP, BASE_W'(0), SIZE_W'(0), ENTRY_W'(31));
        send_word(ACT_RSVD, BASE_MAX, SIZE_MAX, ENTRY_W'(31));
        send_word(ACT_RSVD, BASE_W'(0), SIZE_W'(0), ENTRY_W'(0));
        send_word(ACT_UNMAP, BASE_W'(0), SIZE_W'(0), ENTRY_W'(0));
        send_word(ACT_MAP, BASE_W'(24'h800000), SIZE_W'(65535), ENTRY_W'(16));
        send_word(ACT_QUERY, BASE_W'(0), SIZE_W'(0), ENTRY_W'(0));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (span == 0) begin
                mix  = t_mix'($urandom_range(2));
                span = $urandom_range(20, 80);
            end else begin
                span--;
            end
            random_word(mix);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
